### hdl/byte_ring_with_commit_border_macros.svh
// ----------------------------------------------------------------------------
// Byte ring assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_WITH_COMMIT_BORDER_MACROS_SVH
`define BYTE_RING_WITH_COMMIT_BORDER_MACROS_SVH

// Same-cycle implication.
`define BRCB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BRCB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/brcb_pkg.sv
// ----------------------------------------------------------------------------
// Byte ring package
// Command and response types, opcodes and fixed field widths.
// ----------------------------------------------------------------------------
package brcb_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned CFG_W  = 11;
  localparam int unsigned OUT_W  = 10;

  localparam int unsigned RING_LEN_RST = 1024;
  localparam int unsigned RING_LEN_MIN = 2;

  localparam logic [OP_W-1:0] OP_PUT     = 3'd0;
  localparam logic [OP_W-1:0] OP_BORDER  = 3'd1;
  localparam logic [OP_W-1:0] OP_RESERVE = 3'd2;
  localparam logic [OP_W-1:0] OP_FILL    = 3'd3;
  localparam logic [OP_W-1:0] OP_RETURN  = 3'd4;
  localparam logic [OP_W-1:0] OP_PEEK    = 3'd5;
  localparam logic [OP_W-1:0] OP_CONSUME = 3'd6;
  localparam logic [OP_W-1:0] OP_STATUS  = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] data_byte;
    logic [POS_W-1:0]  position;
    logic [CNT_W-1:0]  count;
  } cmd_t;

  typedef struct packed {
    logic              accepted;
    logic [BYTE_W-1:0] read_byte;
    logic [OUT_W-1:0]  reserved_offset;
    logic [OUT_W-1:0]  readable_length;
    logic [OUT_W-1:0]  data_size;
    logic [OUT_W-1:0]  free_space;
    logic              border_present;
  } rsp_t;

endpackage

### hdl/brcb_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module brcb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/brcb_mod.sv
// ----------------------------------------------------------------------------
// Byte ring remainder unit
// Restoring shift-subtract remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module brcb_mod #(
  parameter int unsigned W = 12
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] rem_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic          run_q, run_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  num_q, num_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  shifted;

  // divisor stays at or below 2^(W-1), so the shifted remainder fits in W bits
  assign shifted = {rem_q[W-2:0], num_q[W-1]};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CW'(W);
      num_d = dividend_i;
      rem_d = '0;
    end else if (run_q) begin
      rem_d = (shifted >= divisor_i) ? shifted - divisor_i : shifted;
      num_d = {num_q[W-2:0], 1'b0};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

### hdl/byte_ring_with_commit_border.sv
// ----------------------------------------------------------------------------
// Byte ring with commit border
// Channel  | ports                           | transfer
// command  | start, busy, cmd_i              | start high while busy low
// result   | result_valid_o, rsp_o           | one-cycle strobe, no back-pressure
// config   | cfg_we_i, cfg_wdata_i           | cfg_we_i high, taken at once
//
// An item passes through the EXEC and RESP states before the result strobe;
// the next item is taken in the strobe cycle. Consume also waits in the MOD
// state for the shift-subtract remainder unit (W = 12 at the default depth).
// Reset is asynchronous and empties the ring; the byte store is not cleared.
// The result side cannot stall.
// ----------------------------------------------------------------------------
module byte_ring_with_commit_border #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  brcb_pkg::cmd_t                cmd_i,
  output logic                          result_valid_o,
  output brcb_pkg::rsp_t                rsp_o,
  input  logic                          cfg_we_i,
  input  logic [brcb_pkg::CFG_W-1:0]    cfg_wdata_i
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned XW = ((PW > brcb_pkg::CFG_W) ? PW : brcb_pkg::CFG_W) + 1;
  localparam int unsigned LEN_RST_I =
    (DEPTH < brcb_pkg::RING_LEN_RST) ? DEPTH : brcb_pkg::RING_LEN_RST;
  localparam logic [XW-1:0] LEN_RST = XW'(LEN_RST_I);
  localparam logic [XW-1:0] LEN_MIN = XW'(brcb_pkg::RING_LEN_MIN);
  localparam logic [XW-1:0] LEN_MAX = XW'(DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_MOD  = 4'b0100,
    ST_RESP = 4'b1000
  } state_e;

  state_e                            state_q;
  brcb_pkg::cmd_t                    cmd_q;
  logic [PW-1:0]                     head_q, tail_q, border_q;
  logic                              bv_q;
  logic [XW-1:0]                     len_q;
  logic                              acc_q;
  logic [brcb_pkg::OUT_W-1:0]        ro_q;
  brcb_pkg::rsp_t                    rsp_q;
  logic                              strobe_q;

  logic [XW-1:0] cfg_x, len_d;
  logic [XW-1:0] head_x, tail_x, border_x, pos_x, cnt_x;
  logic [XW-1:0] free_x, size_x, readable_x;
  logic [XW-1:0] head_inc, head_put, head_sum, head_res, peek_sum;
  logic          put_ok, res_ok, pos_ok, peek_ok;
  logic          mem_we;
  logic [PW-1:0] mem_waddr;
  logic [7:0]    mem_rdata;
  logic          mod_start, mod_done;
  logic [XW-1:0] mod_rem;

  assign cfg_x = XW'(cfg_wdata_i);
  assign len_d = (cfg_x < LEN_MIN) ? LEN_MIN : ((cfg_x > LEN_MAX) ? LEN_MAX : cfg_x);

  assign head_x   = XW'(head_q);
  assign tail_x   = XW'(tail_q);
  assign border_x = XW'(border_q);
  assign pos_x    = XW'(cmd_q.position);
  assign cnt_x    = XW'(cmd_q.count);

  // occupancy views of the current pointers
  assign free_x = (tail_x <= head_x) ? tail_x + len_q - head_x - XW'(1)
                                     : tail_x - head_x - XW'(1);
  assign size_x = !bv_q ? '0 : ((tail_x <= head_x) ? head_x - tail_x
                                                   : len_q - tail_x + head_x);
  assign readable_x = (!bv_q || (head_q == tail_q)) ? '0 :
                      ((border_x >= tail_x) ? border_x - tail_x : len_q - tail_x);

  assign head_inc = head_x + XW'(1);
  assign head_put = (head_inc == len_q) ? '0 : head_inc;
  assign head_sum = head_x + cnt_x;
  assign head_res = (head_sum >= len_q) ? head_sum - len_q : head_sum;
  assign peek_sum = tail_x + pos_x;

  assign put_ok  = (free_x != '0);
  assign res_ok  = (cnt_x <= free_x);
  assign pos_ok  = (pos_x < len_q);
  assign peek_ok = (pos_x < readable_x);

  assign mem_we    = (state_q == ST_EXEC) &&
                     (((cmd_q.operation == brcb_pkg::OP_PUT) && put_ok) ||
                      ((cmd_q.operation == brcb_pkg::OP_FILL) && pos_ok));
  assign mem_waddr = (cmd_q.operation == brcb_pkg::OP_PUT) ? head_q : pos_x[PW-1:0];

  brcb_ram #(
    .WIDTH (brcb_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (cmd_q.data_byte),
    .raddr_i (peek_sum[PW-1:0]),
    .rdata_o (mem_rdata)
  );

  assign mod_start = (state_q == ST_EXEC) && (cmd_q.operation == brcb_pkg::OP_CONSUME);

  brcb_mod #(
    .W (XW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (tail_x + cnt_x),
    .divisor_i  (len_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      head_q   <= '0;
      tail_q   <= '0;
      border_q <= '0;
      bv_q     <= 1'b0;
      len_q    <= LEN_RST;
      acc_q    <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      if (cfg_we_i) begin
        // new length empties the ring
        len_q    <= len_d;
        head_q   <= '0;
        tail_q   <= '0;
        border_q <= '0;
        bv_q     <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_q <= ST_RESP;
          acc_q   <= 1'b1;
          case (cmd_q.operation)
            brcb_pkg::OP_PUT: begin
              acc_q <= put_ok;
              if (put_ok) begin
                head_q <= head_put[PW-1:0];
              end
            end
            brcb_pkg::OP_BORDER: begin
              border_q <= head_q;
              bv_q     <= 1'b1;
            end
            brcb_pkg::OP_RESERVE: begin
              acc_q <= res_ok;
              if (res_ok) begin
                head_q <= head_res[PW-1:0];
              end
            end
            brcb_pkg::OP_FILL: begin
              acc_q <= pos_ok;
            end
            brcb_pkg::OP_RETURN: begin
              acc_q <= pos_ok;
              if (pos_ok) begin
                head_q <= pos_x[PW-1:0];
              end
            end
            brcb_pkg::OP_PEEK: begin
              acc_q <= peek_ok;
            end
            brcb_pkg::OP_CONSUME: begin
              state_q <= ST_MOD;
            end
            default: begin
            end
          endcase
        end
        ST_MOD: begin
          if (mod_done) begin
            tail_q <= mod_rem[PW-1:0];
            // drop the border once the reader reaches it
            if (bv_q && (mod_rem == border_x)) begin
              bv_q <= 1'b0;
            end
            state_q <= ST_RESP;
          end
        end
        ST_RESP: begin
          strobe_q <= 1'b1;
          state_q  <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && start) begin
      cmd_q <= cmd_i;
    end
    if (state_q == ST_EXEC) begin
      ro_q <= ((cmd_q.operation == brcb_pkg::OP_RESERVE) && res_ok) ?
              head_x[brcb_pkg::OUT_W-1:0] : '0;
    end
    if (state_q == ST_RESP) begin
      rsp_q.accepted        <= acc_q;
      rsp_q.read_byte       <= (acc_q && (cmd_q.operation == brcb_pkg::OP_PEEK)) ?
                               mem_rdata : '0;
      rsp_q.reserved_offset <= ro_q;
      rsp_q.readable_length <= readable_x[brcb_pkg::OUT_W-1:0];
      rsp_q.data_size       <= size_x[brcb_pkg::OUT_W-1:0];
      rsp_q.free_space      <= free_x[brcb_pkg::OUT_W-1:0];
      rsp_q.border_present  <= bv_q;
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = strobe_q;
  assign rsp_o          = rsp_q;

endmodule

### hdl/brcb_chk.sv
// ----------------------------------------------------------------------------
// Byte ring port checker
// Watches command and result transfers on the top-level ports.
// ----------------------------------------------------------------------------
`include "byte_ring_with_commit_border_macros.svh"

module brcb_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic                       result_valid_o,
  input brcb_pkg::rsp_t             rsp_o
);

  `BRCB_ASSERT_NXT(a_busy_after_take, start && !busy, busy && !result_valid_o, "busy not raised after command transfer")
  `BRCB_ASSERT_IMP(a_result_when_free, result_valid_o, !busy, "result strobe while busy")
  `BRCB_ASSERT_NXT(a_single_strobe, result_valid_o, !result_valid_o, "result strobe longer than one cycle")
  `BRCB_ASSERT_IMP(a_no_border_empty, result_valid_o && !rsp_o.border_present, (rsp_o.readable_length == '0) && (rsp_o.data_size == '0), "committed bytes reported without a border")

endmodule

bind byte_ring_with_commit_border brcb_chk u_brcb_chk (.*);
